// ----- design/ovt_pkg.sv -----
package ovt_pkg;

  localparam logic [3:0] K_APPEND  = 4'd0;
  localparam logic [3:0] K_PREPEND = 4'd1;
  localparam logic [3:0] K_INSERT  = 4'd2;
  localparam logic [3:0] K_RMAT    = 4'd3;
  localparam logic [3:0] K_RMVAL   = 4'd4;
  localparam logic [3:0] K_FIND    = 4'd5;
  localparam logic [3:0] K_READ    = 4'd6;
  localparam logic [3:0] K_PRED    = 4'd7;
  localparam logic [3:0] K_CLEAR   = 4'd8;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADPOS  = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;

  localparam logic REG_KEEP_SORTED    = 1'b0;
  localparam logic REG_PERMIT_REPEATS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_LAST, S_MID, S_CHECK, S_SCAN,
    S_FETCH, S_SHUP, S_PUT, S_SHDN, S_DONE
  } state_t;

  typedef struct packed {
    logic keep_sorted;
    logic permit_repeats;
  } mode_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [6:0]         where;
    logic signed [31:0] read_value;
    logic [6:0]         fill;
  } result_t;

endpackage

// ----- design/ovt_ram.sv -----
module ovt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/ovt_ctrl.sv -----
module ovt_ctrl import ovt_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int CW       = $clog2(CAPACITY + 1),
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [3:0]         in_kind,
  input  logic signed [31:0] in_item_value,
  input  logic [6:0]         in_slot,
  output logic               in_stall,
  input  mode_t              mode,
  output logic               res_valid,
  input  logic               res_take,
  output result_t            res,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [31:0]        ram_wdata,
  output logic [AW-1:0]      ram_raddr,
  input  logic [31:0]        ram_rdata
);

  localparam int MW = CW + 1;
  localparam int XW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  state_t             state_r, state_nxt;
  logic [3:0]         kind_r, kind_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      ipos_r, ipos_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic signed [MW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [2:0]         status_r, status_nxt;
  logic [CW-1:0]      where_r, where_nxt;
  logic signed [31:0] rv_r, rv_nxt;

  logic [3:0]         kind_c;
  logic signed [31:0] val_c, e_c;
  logic [CW-1:0]      ipos_c;
  logic               start_look;
  logic               ord_done;
  logic [CW-1:0]      ord_pos;
  logic               look_done, look_hit;
  logic [CW-1:0]      look_pos;
  logic               shdn_go;
  logic [CW-1:0]      shdn_pos;
  logic signed [MW-1:0] lo_c, hi_c;
  logic [MW:0]        sum_c;

  assign e_c = $signed(ram_rdata);

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    ipos_nxt   = ipos_r;
    idx_nxt    = idx_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    status_nxt = status_r;
    where_nxt  = where_r;
    rv_nxt     = rv_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = val_r;
    ram_raddr  = '0;
    kind_c     = (state_r == S_IDLE) ? in_kind : kind_r;
    val_c      = (state_r == S_IDLE) ? in_item_value : val_r;
    ipos_c     = ipos_r;
    start_look = 1'b0;
    ord_done   = 1'b0;
    ord_pos    = '0;
    look_done  = 1'b0;
    look_hit   = 1'b0;
    look_pos   = '0;
    shdn_go    = 1'b0;
    shdn_pos   = '0;
    lo_c       = lo_r;
    hi_c       = hi_r;
    sum_c      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_kind;
          val_nxt    = in_item_value;
          status_nxt = ST_OK;
          where_nxt  = '0;
          rv_nxt     = '0;
          state_nxt  = S_DONE;
          case (in_kind)
            K_APPEND, K_PREPEND, K_INSERT: begin
              if (in_kind == K_APPEND) begin
                ipos_c = cnt_r;
              end else if (in_kind == K_PREPEND) begin
                ipos_c = '0;
              end else begin
                ipos_c = CW'(in_slot);
              end
              ipos_nxt = ipos_c;
              if (mode.keep_sorted) begin
                start_look = 1'b1;
              end else if (in_kind == K_INSERT && XW'(in_slot) > XW'(cnt_r)) begin
                status_nxt = ST_BADPOS;
              end else if (mode.permit_repeats) begin
                look_done = 1'b1;
              end else begin
                start_look = 1'b1;
              end
            end
            K_RMAT, K_READ: begin
              if (XW'(in_slot) >= XW'(cnt_r)) begin
                status_nxt = ST_BADPOS;
              end else begin
                ram_raddr = AW'(in_slot);
                where_nxt = CW'(in_slot);
                state_nxt = S_FETCH;
              end
            end
            K_RMVAL, K_FIND, K_PRED: begin
              start_look = 1'b1;
            end
            K_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_FIRST: begin
        if (val_r < e_c) begin
          ord_done = 1'b1;
        end else begin
          ram_raddr = AW'(cnt_r - 1'b1);
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        if (val_r > e_c) begin
          ord_done = 1'b1;
          ord_pos  = cnt_r;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = MW'(cnt_r - 1'b1);
          mid_nxt   = MW'((cnt_r - 1'b1) >> 1);
          ram_raddr = AW'((cnt_r - 1'b1) >> 1);
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        if (val_r > e_c) begin
          lo_c = mid_r + 1'b1;
        end else if (val_r < e_c) begin
          hi_c = mid_r - 1'b1;
        end
        if (val_r == e_c) begin
          ord_done = 1'b1;
          ord_pos  = CW'(mid_r);
        end else if (lo_c <= hi_c) begin
          sum_c     = (MW + 1)'($unsigned(lo_c)) + (MW + 1)'($unsigned(hi_c));
          lo_nxt    = lo_c;
          hi_nxt    = hi_c;
          mid_nxt   = MW'(sum_c >> 1);
          ram_raddr = AW'(sum_c >> 1);
        end else begin
          ord_done = 1'b1;
          ord_pos  = (lo_c > mid_r) ? CW'(mid_r + 1'b1) : CW'(mid_r);
        end
      end
      S_CHECK: begin
        look_done = 1'b1;
        look_hit  = (e_c == val_r);
        look_pos  = idx_r;
      end
      S_SCAN: begin
        if (e_c == val_r) begin
          look_done = 1'b1;
          look_hit  = 1'b1;
          look_pos  = idx_r;
        end else if (idx_r + 1'b1 < cnt_r) begin
          ram_raddr = AW'(idx_r + 1'b1);
          idx_nxt   = idx_r + 1'b1;
        end else begin
          look_done = 1'b1;
        end
      end
      S_FETCH: begin
        rv_nxt = e_c;
        if (kind_r == K_RMAT) begin
          shdn_go  = 1'b1;
          shdn_pos = where_r;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHUP: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_r);
        ram_wdata = ram_rdata;
        if (idx_r - 1'b1 > ipos_r) begin
          ram_raddr = AW'(idx_r - 2'd2);
          idx_nxt   = idx_r - 1'b1;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ipos_r);
        ram_wdata = val_r;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_SHDN: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_r - 1'b1);
        ram_wdata = ram_rdata;
        if (idx_r + 1'b1 < cnt_r) begin
          ram_raddr = AW'(idx_r + 1'b1);
          idx_nxt   = idx_r + 1'b1;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // begin a lookup: binary search when sorted, else a linear scan
    if (start_look) begin
      if (cnt_r == '0) begin
        if (mode.keep_sorted) begin
          ord_done = 1'b1;
        end else begin
          look_done = 1'b1;
        end
      end else begin
        ram_raddr = '0;
        idx_nxt   = '0;
        state_nxt = mode.keep_sorted ? S_FIRST : S_SCAN;
      end
    end

    if (ord_done) begin
      if (ord_pos < cnt_r) begin
        ram_raddr = AW'(ord_pos);
        idx_nxt   = ord_pos;
        state_nxt = S_CHECK;
      end else begin
        look_done = 1'b1;
        look_hit  = 1'b0;
        look_pos  = ord_pos;
      end
    end

    if (look_done) begin
      state_nxt = S_DONE;
      case (kind_c)
        K_APPEND, K_PREPEND, K_INSERT: begin
          if (mode.keep_sorted) begin
            ipos_c = look_pos;
          end
          ipos_nxt = ipos_c;
          if (!mode.permit_repeats && look_hit) begin
            status_nxt = ST_DUP;
          end else if (cnt_r >= CAP) begin
            status_nxt = ST_FULL;
          end else begin
            where_nxt = ipos_c;
            rv_nxt    = val_c;
            if (ipos_c == cnt_r) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(ipos_c);
              ram_wdata = val_c;
              cnt_nxt   = cnt_r + 1'b1;
            end else begin
              ram_raddr = AW'(cnt_r - 1'b1);
              idx_nxt   = cnt_r;
              state_nxt = S_SHUP;
            end
          end
        end
        K_RMVAL: begin
          if (!look_hit) begin
            status_nxt = ST_MISSING;
          end else begin
            where_nxt = look_pos;
            rv_nxt    = val_c;
            shdn_go   = 1'b1;
            shdn_pos  = look_pos;
          end
        end
        K_FIND: begin
          if (!look_hit) begin
            status_nxt = ST_MISSING;
          end else begin
            where_nxt = look_pos;
            rv_nxt    = val_c;
          end
        end
        K_PRED: begin
          if (!look_hit) begin
            status_nxt = ST_MISSING;
          end else if (look_pos == '0) begin
            status_nxt = ST_BADPOS;
          end else begin
            where_nxt = look_pos - 1'b1;
            ram_raddr = AW'(look_pos - 1'b1);
            state_nxt = S_FETCH;
          end
        end
        default: begin
          state_nxt = S_DONE;
        end
      endcase
    end

    // close the gap left by a removed entry
    if (shdn_go) begin
      if (shdn_pos + 1'b1 < cnt_r) begin
        ram_raddr = AW'(shdn_pos + 1'b1);
        idx_nxt   = shdn_pos + 1'b1;
        state_nxt = S_SHDN;
      end else begin
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = S_DONE;
      end
    end
  end

  always_comb begin
    in_stall       = (state_r != S_IDLE);
    res_valid      = (state_r == S_DONE);
    res.status     = status_r;
    res.where      = 7'(where_r);
    res.read_value = rv_r;
    res.fill       = 7'(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    val_r    <= val_nxt;
    ipos_r   <= ipos_nxt;
    idx_r    <= idx_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    status_r <= status_nxt;
    where_r  <= where_nxt;
    rv_r     <= rv_nxt;
  end

endmodule

// ----- design/ordered_value_table.sv -----
// Ordered value table: a packed list of up to CAPACITY signed 32-bit values.
// Input channel: in_valid/in_stall with in_kind, in_item_value, in_slot.
// One operation (append, prepend, insert, remove, find, read, predecessor,
// clear) is taken at a time; in_stall is high while it is in progress.
// Result channel: out_valid/out_stall with status, position, value and fill.
// Every item gives exactly one result, in order.
// A sorted lookup is a binary search after checks of the first and last
// entry, an unsorted lookup a linear scan of up to fill entries; insert and
// remove then move every later entry one place, one entry per cycle. The
// rate is set by the single read and single write port of the entry memory.
// The result sits in an output register; a stalled result holds there and
// the next item is taken once the block has finished and that register can
// accept a new result.
// Reset (rst_n low, synchronous) empties the table and clears both mode
// registers; cfg_we with cfg_index writes keep_sorted (0) or
// permit_repeats (1) and should only be used while the block is idle.
module ordered_value_table import ovt_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_kind,
  input  logic signed [31:0] in_item_value,
  input  logic [6:0]         in_slot,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [6:0]         out_where,
  output logic signed [31:0] out_read_value,
  output logic [6:0]         out_fill,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic               cfg_wdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  mode_t         mode_r;
  logic          out_valid_r;
  result_t       out_r;
  logic          res_valid, res_take;
  result_t       res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_KEEP_SORTED) begin
        mode_r.keep_sorted <= cfg_wdata;
      end else if (cfg_index == REG_PERMIT_REPEATS) begin
        mode_r.permit_repeats <= cfg_wdata;
      end
    end
  end

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_where      = out_r.where;
  assign out_read_value = out_r.read_value;
  assign out_fill       = out_r.fill;

  ovt_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ovt_ctrl #(
    .CAPACITY(CAPACITY),
    .CW      (CW),
    .AW      (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_kind      (in_kind),
    .in_item_value(in_item_value),
    .in_slot      (in_slot),
    .in_stall     (in_stall),
    .mode         (mode_r),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

endmodule

// ----- tb/ordered_value_table_tb.sv -----
`timescale 1ns / 1ps

module ordered_value_table_tb;
  import ovt_pkg::*;

  localparam int CAP = 64;

  class table_scoreboard;
    logic signed [31:0] vals[CAP];
    int                 count;
    bit                 sorted_mode;
    bit                 repeats_ok;
    result_t            pending[$];
    int                 errors;
    int                 checked;

    function new();
      count = 0;
      sorted_mode = 0;
      repeats_ok = 0;
      errors = 0;
      checked = 0;
    endfunction

    function int sorted_pos(logic signed [31:0] v);
      int lo, hi, mid;
      if (count == 0 || v < vals[0]) return 0;
      if (v > vals[count - 1]) return count;
      lo = 0;
      hi = count - 1;
      mid = 0;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (v > vals[mid]) lo = mid + 1;
        else if (v == vals[mid]) return mid;
        else hi = mid - 1;
      end
      if (lo > mid) mid++;
      return mid;
    endfunction

    function int locate(logic signed [31:0] v);
      int p;
      if (sorted_mode) begin
        p = sorted_pos(v);
        if (p < count && vals[p] == v) return p;
        return -1;
      end
      for (int i = 0; i < count; i++)
        if (vals[i] == v) return i;
      return -1;
    endfunction

    function void drop(int p);
      for (int i = p + 1; i < count; i++) vals[i - 1] = vals[i];
      count--;
    endfunction

    function void note_item(logic [3:0] kind, logic signed [31:0] v, logic [6:0] slot);
      result_t r;
      int p;
      r = '0;
      case (kind)
        K_APPEND, K_PREPEND, K_INSERT: begin
          p = (kind == K_APPEND) ? count : (kind == K_PREPEND) ? 0 : int'(slot);
          if (sorted_mode) p = sorted_pos(v);
          if (p > count) r.status = ST_BADPOS;
          else if (!repeats_ok && locate(v) >= 0) r.status = ST_DUP;
          else if (count >= CAP) r.status = ST_FULL;
          else begin
            for (int j = count; j > p; j--) vals[j] = vals[j - 1];
            vals[p] = v;
            count++;
            r.where = p[6:0];
            r.read_value = v;
          end
        end
        K_RMAT, K_READ: begin
          if (slot >= count) r.status = ST_BADPOS;
          else begin
            r.where = slot;
            r.read_value = vals[slot];
            if (kind == K_RMAT) drop(slot);
          end
        end
        K_RMVAL, K_FIND, K_PRED: begin
          p = locate(v);
          if (p < 0) r.status = ST_MISSING;
          else if (kind == K_PRED) begin
            if (p == 0) r.status = ST_BADPOS;
            else begin
              r.where = 7'(p - 1);
              r.read_value = vals[p - 1];
            end
          end else begin
            r.where = p[6:0];
            r.read_value = vals[p];
            if (kind == K_RMVAL) drop(p);
          end
        end
        K_CLEAR: count = 0;
        default: ;
      endcase
      r.fill = count[6:0];
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t e;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) report_mismatch("status", got.status, e.status);
      if (got.where !== e.where) report_mismatch("where", got.where, e.where);
      if (got.read_value !== e.read_value)
        report_mismatch("read_value", got.read_value, e.read_value);
      if (got.fill !== e.fill) report_mismatch("fill", got.fill, e.fill);
    endfunction

    function void report_mismatch(string what, longint got, longint want);
      errors++;
      if (errors <= 30)
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, checked);
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [3:0]         in_kind = '0;
  logic signed [31:0] in_item_value = '0;
  logic [6:0]         in_slot = '0;
  logic               out_valid;
  logic               out_stall = 1;
  logic [2:0]         out_status;
  logic [6:0]         out_where;
  logic signed [31:0] out_read_value;
  logic [6:0]         out_fill;
  logic               cfg_we = 0;
  logic               cfg_index = 0;
  logic               cfg_wdata = 0;

  table_scoreboard sb = new();
  bit              calm = 0;
  bit              hold_off = 0;
  int              items_sent = 0;
  logic signed [31:0] used_vals[$];

  always #1 clk = ~clk;

  ordered_value_table #(.CAPACITY(CAP)) u_dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_status, out_where, out_read_value, out_fill});
  end

  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        @(negedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 6);
        out_stall <= 1;
        repeat (n) @(negedge clk);
      end else begin
        out_stall <= 0;
        @(negedge clk);
      end
    end
  end

  task automatic send_item(logic [3:0] kind, logic signed [31:0] v, logic [6:0] slot);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1;
    in_kind <= kind;
    in_item_value <= v;
    in_slot <= slot;
    do @(posedge clk); while (in_stall);
    sb.note_item(kind, v, slot);
    items_sent++;
    if (used_vals.size() < 200) used_vals.push_back(v);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_mode(bit sorted, bit repeats);
    drain();
    cfg_we <= 1;
    cfg_index <= REG_KEEP_SORTED;
    cfg_wdata <= sorted;
    @(negedge clk);
    cfg_index <= REG_PERMIT_REPEATS;
    cfg_wdata <= repeats;
    @(negedge clk);
    cfg_we <= 0;
    sb.sorted_mode = sorted;
    sb.repeats_ok = repeats;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom();
      default: begin
        if (used_vals.size() != 0)
          return used_vals[$urandom_range(0, used_vals.size() - 1)];
        return $signed(32'($urandom_range(0, 40)) - 20);
      end
    endcase
  endfunction

  task automatic random_phase(int count_items, int insert_weight);
    logic [3:0] k;
    int r;
    for (int i = 0; i < count_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < insert_weight) k = 4'($urandom_range(0, 2));
      else if (r < 98) k = 4'($urandom_range(3, 7));
      else if (r < 99) k = K_CLEAR;
      else k = 4'($urandom_range(9, 15));
      send_item(k, pick_value(),
                ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                             : 7'($urandom_range(0, sb.count + 1)));
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    send_item(K_READ, 0, 0);
    send_item(K_RMAT, 0, 0);
    send_item(K_FIND, 5, 0);
    send_item(K_PRED, 5, 0);
    send_item(K_APPEND, 32'sh7fffffff, 0);
    send_item(K_PREPEND, 32'sh80000000, 0);
    send_item(K_INSERT, 0, 1);
    send_item(K_INSERT, 7, 9);
    send_item(K_INSERT, 7, 127);
    send_item(K_APPEND, 0, 0);
    send_item(K_PRED, 32'sh80000000, 0);
    send_item(K_PRED, 0, 0);
    send_item(K_FIND, 32'sh7fffffff, 0);
    send_item(K_READ, 0, 2);
    send_item(K_RMVAL, 0, 0);
    send_item(K_RMVAL, 99, 0);
    send_item(K_RMAT, 0, 3);
    send_item(K_RMAT, 0, 1);
    send_item(4'd9, 1, 1);
    send_item(4'd15, -1, 127);
    send_item(K_CLEAR, 0, 0);

    write_mode(0, 1);
    for (int i = 0; i < 66; i++) send_item(K_APPEND, i % 5, 0);
    write_mode(0, 0);
    random_phase(350, 50);
    send_item(K_CLEAR, 0, 0);

    write_mode(1, 0);
    hold_off = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 70; i++) send_item(K_INSERT, $urandom(), 7'($urandom_range(0, 127)));
    join
    random_phase(350, 45);
    send_item(K_CLEAR, 0, 0);

    write_mode(1, 1);
    random_phase(350, 55);
    send_item(K_CLEAR, 0, 0);

    write_mode(0, 1);
    random_phase(250, 50);
    write_mode(1, 1);
    random_phase(50, 50);
    calm = 1;
    write_mode(0, 0);
    send_item(K_CLEAR, 0, 0);
    random_phase(200, 55);

    drain();
    $display("covered %0d items over both table orders and repeat settings,", items_sent);
    $display("including full table, bad positions, duplicates and a long output hold-off");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout");
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
design/ovt_pkg.sv
design/ovt_ram.sv
design/ovt_ctrl.sv
design/ordered_value_table.sv
tb/ordered_value_table_tb.sv
